// File: src/imuca_pkg.sv
// imuca_pkg: shared constants, types and lookup functions for the attitude estimator
// no dependencies; used by the arithmetic units and the top level
`timescale 1ns / 1ps
`default_nettype none

package imuca_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int COUNT_BITS   = 16;

   localparam int CORDIC_CW = $clog2(CORDIC_STEPS + 1);
   localparam int CX_W      = 36;   // cordic x/y datapath, covers gain on 32-bit inputs
   localparam int CZ_W      = 26;   // cordic angle accumulator
   localparam int DIV_N     = 50;   // dividend / quotient width
   localparam int DIV_D     = 23;   // divisor width
   localparam int DIV_CW    = $clog2(DIV_N);
   localparam int MA_W      = 35;   // shared multiplier operand a
   localparam int MB_W      = 22;   // shared multiplier operand b
   localparam int MP_W      = MA_W + MB_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   localparam logic [1:0]  GYRO_RANGE_RST   = 2'd1;
   localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
   localparam logic [19:0] TIME_STEP_RST    = 20'd10486;

   typedef enum logic [1:0] {
      ACT_UPDATE = 2'd0,
      ACT_CAL    = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL_RANGE  = 2'd0,
      CSR_GYRO_RANGE   = 2'd1,
      CSR_BLEND_WEIGHT = 2'd2,
      CSR_TIME_STEP    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE,
      ST_NUM,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DIV_STORE,
      ST_ATAN_GO,
      ST_ATAN_WAIT,
      ST_ATAN_STORE,
      ST_BL_G,
      ST_BL_A,
      ST_BL_STORE,
      ST_OUT
   } state_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic [CZ_W-1:0] atan_entry(input logic [4:0] i);
      logic [CZ_W-1:0] v;
      case (i)
         5'd0:  v = CZ_W'(2949120);
         5'd1:  v = CZ_W'(1740967);
         5'd2:  v = CZ_W'(919879);
         5'd3:  v = CZ_W'(466945);
         5'd4:  v = CZ_W'(234379);
         5'd5:  v = CZ_W'(117304);
         5'd6:  v = CZ_W'(58666);
         5'd7:  v = CZ_W'(29335);
         5'd8:  v = CZ_W'(14668);
         5'd9:  v = CZ_W'(7334);
         5'd10: v = CZ_W'(3667);
         5'd11: v = CZ_W'(1833);
         5'd12: v = CZ_W'(917);
         5'd13: v = CZ_W'(458);
         5'd14: v = CZ_W'(229);
         5'd15: v = CZ_W'(115);
         5'd16: v = CZ_W'(57);
         5'd17: v = CZ_W'(29);
         5'd18: v = CZ_W'(14);
         5'd19: v = CZ_W'(7);
         5'd20: v = CZ_W'(4);
         5'd21: v = CZ_W'(2);
         5'd22: v = CZ_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // ten times counts per deg/s, times 4096
   function automatic logic [DIV_D-1:0] gyro_den(input logic [1:0] r);
      logic [DIV_D-1:0] v;
      case (r)
         2'd0:    v = DIV_D'(5365760);
         2'd1:    v = DIV_D'(2682880);
         2'd2:    v = DIV_D'(1343488);
         default: v = DIV_D'(671744);
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [MP_W-1:0] v);
      logic signed [31:0] r;
      if (v > MP_W'(64'sd2147483647)) r = 32'sh7fffffff;
      else if (v < MP_W'(-64'sd2147483648)) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/imuca_if.sv
// imuca_if: request and response channel interfaces (valid/ready plus payload)
// depends on nothing; used by the top level
`timescale 1ns / 1ps
`default_nettype none

interface imuca_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;

   modport source (output valid, action, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   input ready);
   modport sink (input valid, action, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 output ready);
endinterface

interface imuca_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] roll_deg;
   logic signed [31:0] pitch_deg;
   logic signed [31:0] yaw_deg;

   modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
   modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

`default_nettype wire

// File: src/imuca_div.sv
// imuca_div: unsigned restoring divider, one quotient bit per cycle
// depends on imuca_pkg
`timescale 1ns / 1ps
`default_nettype none

module imuca_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [imuca_pkg::DIV_N-1:0]   dividend,
   input  logic [imuca_pkg::DIV_D-1:0]   divisor,
   output logic                          done,
   output logic [imuca_pkg::DIV_N-1:0]   quotient
);
   import imuca_pkg::*;

   logic [DIV_D-1:0]  rem_ff, rem_in;
   logic [DIV_N-1:0]  quo_ff, quo_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_D:0]    trial;
   logic              fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_N-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? DIV_D'(trial - {1'b0, divisor}) : DIV_D'(trial);
         quo_in = {quo_ff[DIV_N-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_N - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: src/imuca_cordic.sv
// imuca_cordic: vectoring cordic atan2, one micro-rotation per cycle
// depends on imuca_pkg (arctangent table, step count)
`timescale 1ns / 1ps
`default_nettype none

module imuca_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] y_in,
   input  logic signed [31:0] x_in,
   output logic               done,
   output logic signed [31:0] angle
);
   import imuca_pkg::*;

   localparam logic signed [CZ_W-1:0] Z_90 = CZ_W'(5898240);

   logic signed [CX_W-1:0] x_ff, x_in_n, y_ff, y_in_n, xs, ys, xe, ye;
   logic signed [CZ_W-1:0] z_ff, z_in, tab;
   logic [CORDIC_CW-1:0]   it_ff, it_in;
   logic                   run_ff, run_in, done_ff, done_in, zero_ff, zero_in;
   logic [4:0]             idx;

   always_comb begin
      xe  = CX_W'(x_in);
      ye  = CX_W'(y_in);
      idx = 5'(it_ff);
      xs  = x_ff >>> idx;
      ys  = y_ff >>> idx;
      tab = signed'(atan_entry(idx));
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         zero_in = (x_in == 32'sd0) && (y_in == 32'sd0);
         run_in  = 1'b1;
         it_in   = '0;
         // quadrant pre-rotation for the left half plane
         if (x_in < 32'sd0) begin
            if (y_in >= 32'sd0) begin
               x_in_n = ye;
               y_in_n = -xe;
               z_in   = Z_90;
            end else begin
               x_in_n = -ye;
               y_in_n = xe;
               z_in   = -Z_90;
            end
         end else begin
            x_in_n = xe;
            y_in_n = ye;
            z_in   = '0;
         end
      end else if (run_ff) begin
         if (y_ff < 0) begin
            x_in_n = x_ff - ys;
            y_in_n = y_ff + xs;
            z_in   = z_ff - tab;
         end else begin
            x_in_n = x_ff + ys;
            y_in_n = y_ff - xs;
            z_in   = z_ff + tab;
         end
         it_in = it_ff + 1'b1;
         if (it_ff == CORDIC_CW'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in_n;
      y_ff    <= y_in_n;
      z_ff    <= z_in;
      it_ff   <= it_in;
      zero_ff <= zero_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign angle = zero_ff ? 32'sd0 : 32'(z_ff);

endmodule

`default_nettype wire

// File: src/imu_complementary_attitude.sv
// imu_complementary_attitude: complementary-filter roll/pitch/yaw estimator
// depends on imuca_pkg, imuca_if, imuca_div, imuca_cordic
//
//  channel  dir  handshake            payload
//  req_chan in   valid/ready          action, accel_x/y/z, gyro_x/y/z
//  rsp_chan out  valid/ready          roll_deg, pitch_deg, yaw_deg
//  csr_*    in   csr_we (no wait)     csr_index, csr_wdata
//
// calibration samples and unused actions go from idle straight to the output state
// an update runs three serial divisions plus two 16-step cordic passes,
// all on one divider, one cordic and one multiplier
// finish runs the same divisions and cordic passes on the same units, without the blend
// synchronous reset restores the register defaults and clears all sums, biases and attitude angles
// a stalled response holds in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none

module imu_complementary_attitude (
   input  logic                              clock,
   input  logic                              reset,
   imuca_req_if.sink                         req_chan,
   imuca_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [imuca_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imuca_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import imuca_pkg::*;

   state_type state_ff, state_in;

   // configuration (accel range cancels in atan2 and is not kept)
   logic [1:0]  gyro_range_ff;
   logic [15:0] weight_ff;
   logic [19:0] ts_ff;

   logic signed [31:0] gsum_ff [3];
   logic signed [31:0] asum_ff [3];
   logic [COUNT_BITS-1:0] count_ff;
   logic signed [23:0] bias_ff [3];
   logic signed [31:0] att_ff [3];

   action_type         act_ff;
   logic signed [15:0] ax_in_ff [3];
   logic signed [15:0] gy_in_ff [3];
   logic [1:0]         sel_ff;
   logic signed [MA_W-1:0] opnd_ff;
   logic [DIV_D-1:0]   den_ff;
   logic signed [MP_W-1:0] prod_ff;
   logic signed [31:0] step_ff [3];
   logic signed [31:0] ang_ff [2];

   logic               rsp_valid_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;

   logic accept, load_out, div_start, cordic_start;
   logic div_done, cordic_done;
   logic [DIV_N-1:0] div_q, dvd;
   logic signed [31:0] cordic_angle, cx, cy;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p, prod_abs, bl_sum;
   logic signed [24:0] corr;
   logic signed [28:0] corr10;
   logic signed [31:0] qmag, qs;
   logic [16:0] inv_w;
   logic [COUNT_BITS-1:0] n_eff;
   logic is_upd;

   assign accept = req_chan.valid && req_chan.ready;
   assign is_upd = (act_ff == ACT_UPDATE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action_type'(req_chan.action) == ACT_UPDATE ||
                   action_type'(req_chan.action) == ACT_FINISH)
                  state_in = ST_PRE;
               else
                  state_in = ST_OUT;
            end
         end
         ST_PRE:      state_in = ST_NUM;
         ST_NUM:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_DIV_STORE;
         ST_DIV_STORE: state_in = (sel_ff == 2'd2) ? ST_ATAN_GO : ST_PRE;
         ST_ATAN_GO:   state_in = ST_ATAN_WAIT;
         ST_ATAN_WAIT: if (cordic_done) state_in = ST_ATAN_STORE;
         ST_ATAN_STORE: begin
            if (sel_ff == 2'd1) state_in = is_upd ? ST_BL_G : ST_OUT;
            else state_in = ST_ATAN_GO;
         end
         ST_BL_G:     state_in = ST_BL_A;
         ST_BL_A:     state_in = ST_BL_STORE;
         ST_BL_STORE: state_in = (sel_ff == 2'd1) ? ST_OUT : ST_BL_G;
         ST_OUT:      if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      cordic_start   = 1'b0;
      load_out       = 1'b0;
      case (state_ff)
         ST_IDLE:    req_chan.ready = 1'b1;
         ST_DIV_GO:  div_start = 1'b1;
         ST_ATAN_GO: cordic_start = 1'b1;
         ST_OUT:     load_out = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   // shared datapath pieces
   always_comb begin
      corr   = 25'(signed'({gy_in_ff[sel_ff], 8'h00})) - 25'(bias_ff[sel_ff]);
      corr10 = (29'(corr) <<< 3) + (29'(corr) <<< 1);
      inv_w  = 17'h10000 - {1'b0, weight_ff};
      n_eff  = (count_ff == '0) ? COUNT_BITS'(1) : count_ff;
      mul_a  = opnd_ff;
      mul_b  = MB_W'(signed'({1'b0, ts_ff}));
      case (state_ff)
         ST_NUM: begin
            mul_a = opnd_ff;
            mul_b = is_upd ? MB_W'(signed'({1'b0, ts_ff})) : MB_W'(256);
         end
         ST_BL_G: begin
            mul_a = (sel_ff == 2'd0) ? MA_W'(att_ff[0]) - MA_W'(step_ff[1])
                                     : MA_W'(att_ff[1]) + MA_W'(step_ff[0]);
            mul_b = MB_W'(signed'({1'b0, weight_ff}));
         end
         ST_BL_A: begin
            mul_a = MA_W'(ang_ff[sel_ff[0]]);
            mul_b = MB_W'(signed'({1'b0, inv_w}));
         end
         default: ;
      endcase
      mul_p    = MP_W'(mul_a) * MP_W'(mul_b);
      prod_abs = prod_ff[MP_W-1] ? -prod_ff : prod_ff;
      dvd      = prod_abs[DIV_N-1:0] + DIV_N'(den_ff >> 1);
      qmag     = signed'({1'b0, div_q[30:0]});
      qs       = prod_ff[MP_W-1] ? -qmag : qmag;
      bl_sum   = (prod_ff + MP_W'(32768)) >>> 16;
      cx = is_upd ? 32'(ax_in_ff[2]) : asum_ff[2];
      cy = is_upd ? 32'(ax_in_ff[sel_ff]) : asum_ff[sel_ff];
   end

   imuca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   imuca_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (cy),
      .x_in  (cx),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gyro_range_ff <= GYRO_RANGE_RST;
         weight_ff     <= BLEND_WEIGHT_RST;
         ts_ff         <= TIME_STEP_RST;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         sel_ff        <= '0;
         for (int k = 0; k < 3; k++) begin
            gsum_ff[k] <= '0;
            asum_ff[k] <= '0;
            bias_ff[k] <= '0;
            att_ff[k]  <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_GYRO_RANGE:   gyro_range_ff <= csr_wdata[1:0];
               CSR_BLEND_WEIGHT: weight_ff <= csr_wdata[15:0];
               CSR_TIME_STEP:    ts_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (accept && action_type'(req_chan.action) == ACT_CAL && count_ff != '1) begin
            gsum_ff[0] <= gsum_ff[0] + 32'(req_chan.gyro_x);
            gsum_ff[1] <= gsum_ff[1] + 32'(req_chan.gyro_y);
            gsum_ff[2] <= gsum_ff[2] + 32'(req_chan.gyro_z);
            asum_ff[0] <= asum_ff[0] + 32'(req_chan.accel_x);
            asum_ff[1] <= asum_ff[1] + 32'(req_chan.accel_y);
            asum_ff[2] <= asum_ff[2] + 32'(req_chan.accel_z);
            count_ff   <= count_ff + 1'b1;
         end

         case (state_ff)
            ST_IDLE: sel_ff <= '0;
            ST_DIV_STORE: begin
               sel_ff <= (sel_ff == 2'd2) ? 2'd0 : sel_ff + 2'd1;
               if (!is_upd) bias_ff[sel_ff] <= qs[23:0];
            end
            ST_ATAN_STORE: begin
               sel_ff <= (sel_ff == 2'd1) ? 2'd0 : 2'd1;
               if (!is_upd) begin
                  att_ff[sel_ff] <= cordic_angle;
                  if (sel_ff == 2'd1) begin
                     att_ff[2] <= '0;
                     count_ff  <= '0;
                     for (int k = 0; k < 3; k++) begin
                        gsum_ff[k] <= '0;
                        asum_ff[k] <= '0;
                     end
                  end
               end
            end
            ST_BL_STORE: begin
               sel_ff <= sel_ff + 2'd1;
               att_ff[sel_ff] <= sat32(bl_sum);
               if (sel_ff == 2'd1)
                  att_ff[2] <= sat32(MP_W'(att_ff[2]) + MP_W'(step_ff[2]));
            end
            default: ;
         endcase

         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= action_type'(req_chan.action);
         ax_in_ff[0] <= req_chan.accel_x;
         ax_in_ff[1] <= req_chan.accel_y;
         ax_in_ff[2] <= req_chan.accel_z;
         gy_in_ff[0] <= req_chan.gyro_x;
         gy_in_ff[1] <= req_chan.gyro_y;
         gy_in_ff[2] <= req_chan.gyro_z;
      end
      case (state_ff)
         ST_PRE: begin
            opnd_ff <= is_upd ? MA_W'(corr10) : MA_W'(gsum_ff[sel_ff]);
            den_ff  <= is_upd ? gyro_den(gyro_range_ff) : DIV_D'(n_eff);
         end
         ST_NUM, ST_BL_G: prod_ff <= mul_p;
         ST_BL_A:         prod_ff <= prod_ff + mul_p;
         ST_DIV_STORE:    if (is_upd) step_ff[sel_ff] <= qs;
         ST_ATAN_STORE:   if (is_upd) ang_ff[sel_ff[0]] <= cordic_angle;
         default: ;
      endcase
      if (load_out) begin
         roll_ff  <= att_ff[0];
         pitch_ff <= att_ff[1];
         yaw_ff   <= att_ff[2];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.roll_deg  = roll_ff;
   assign rsp_chan.pitch_deg = pitch_ff;
   assign rsp_chan.yaw_deg   = yaw_ff;

endmodule

`default_nettype wire
